/* design/rcw_pkg.sv */
// ----------------------------------------------------------------------------
// rcw_pkg
// shared types, constants and the identifier character check
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

    localparam logic [7:0] HeaderSkipReset = 8'd12;

    // byte role codes on the result channel
    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_SEARCH  = 2'd1;
    localparam logic [1:0] ROLE_LENGTH  = 2'd2;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd3;

    // identifier character bounds
    localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    localparam logic [7:0] ID_BYTES = 8'd4;
    localparam logic [7:0] LEN_BYTES = 8'd4;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_SEARCH  = 4'b0010,
        PH_LENGTH  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    function automatic logic char_ok(input logic [7:0] c);
        return (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
               (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
               (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
               (c == CHAR_SPACE);
    endfunction

endpackage

`default_nettype wire

/* design/rcw_id_check.sv */
// ----------------------------------------------------------------------------
// rcw_id_check
// checks that all four bytes of an identifier window are legal characters
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_id_check
    import rcw_pkg::*;
(
    input  wire logic [31:0] window,
    output logic             window_ok
);

    logic [3:0] byte_ok;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            byte_ok[k] = char_ok(window[8*k +: 8]);
        end
    end

    assign window_ok = &byte_ok;

endmodule

`default_nettype wire

/* design/riff_chunk_walker.sv */
// ----------------------------------------------------------------------------
// riff_chunk_walker
// output: the result of an input transfer is registered and offered on the m_ side in the next cycle
// throughput: one byte per cycle, set by the single result register; the
//   input stalls only while that register is full and not taken
// reset: synchronous active-low aresetn clears phase, counters, window,
//   length and the result valid; header_skip_bytes returns to 12
// ----------------------------------------------------------------------------
`default_nettype none

module riff_chunk_walker
    import rcw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // header_skip_bytes register
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,

    // byte stream in
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_stream_end,

    // tagged bytes out
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_byte_role,
    output logic [7:0]       m_payload_byte,
    output logic [31:0]      m_chunk_id,
    output logic [31:0]      m_chunk_length,
    output logic             m_chunk_found,
    output logic             m_payload_last,
    output logic             m_id_rejected,
    output logic             m_end_seen
);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [7:0]  skip_reg;
    phase_t      phase_reg,   phase_next;
    logic [7:0]  count_reg,   count_next;
    logic [31:0] window_reg,  window_next;
    logic [31:0] length_reg,  length_next;
    logic [31:0] left_reg,    left_next;

    logic        out_valid_reg;
    logic [1:0]  role_next;
    logic        found_next;
    logic        last_next;
    logic        rej_next;

    // phase and count after the late header-exit check
    phase_t      eff_phase;
    logic [7:0]  eff_count;
    logic [7:0]  count_inc;
    logic [31:0] len_merged;
    logic        win_ok;
    logic        s_fire;

    // accept whenever the result register is empty or being drained
    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    // window after shifting in the current byte, checked for legal characters
    logic [31:0] window_shift;
    assign window_shift = {s_data_byte, window_reg[31:8]};

    rcw_id_check u_id_check (
        .window    (window_shift),
        .window_ok (win_ok)
    );

    // ------------------------------------------------------------------
    // next-state logic for one byte
    // ------------------------------------------------------------------
    always_comb begin
        // header skip may already be done if the skip count was lowered
        if (phase_reg == PH_HEADER && count_reg >= skip_reg) begin
            eff_phase = PH_SEARCH;
            eff_count = 8'd0;
        end else begin
            eff_phase = phase_reg;
            eff_count = count_reg;
        end

        count_inc  = eff_count + 8'd1;
        len_merged = length_reg | ({24'd0, s_data_byte} << {eff_count[1:0], 3'b000});

        phase_next  = eff_phase;
        count_next  = eff_count;
        window_next = window_reg;
        length_next = length_reg;
        left_next   = left_reg;
        role_next   = ROLE_HEADER;
        found_next  = 1'b0;
        last_next   = 1'b0;
        rej_next    = 1'b0;

        unique case (eff_phase)
            PH_HEADER: begin
                role_next  = ROLE_HEADER;
                count_next = count_inc;
                if (count_inc >= skip_reg) begin
                    phase_next = PH_SEARCH;
                    count_next = 8'd0;
                end
            end
            PH_SEARCH: begin
                role_next   = ROLE_SEARCH;
                window_next = window_shift;
                // count saturates once a full window has been collected
                if (eff_count < ID_BYTES) begin
                    count_next = count_inc;
                end
                if (count_next >= ID_BYTES) begin
                    if (win_ok) begin
                        phase_next  = PH_LENGTH;
                        count_next  = 8'd0;
                        length_next = 32'd0;
                    end else begin
                        rej_next = 1'b1;
                    end
                end
            end
            PH_LENGTH: begin
                role_next   = ROLE_LENGTH;
                length_next = len_merged;
                count_next  = count_inc;
                if (count_inc >= LEN_BYTES) begin
                    found_next = 1'b1;
                    left_next  = len_merged;
                    count_next = 8'd0;
                    phase_next = (len_merged != 32'd0) ? PH_PAYLOAD : PH_SEARCH;
                end
            end
            PH_PAYLOAD: begin
                role_next = ROLE_PAYLOAD;
                if (left_reg <= 32'd1) begin
                    left_next  = 32'd0;
                    last_next  = 1'b1;
                    phase_next = PH_SEARCH;
                    count_next = 8'd0;
                end else begin
                    left_next = left_reg - 32'd1;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // a length cut off by stream end still reports the chunk
        if (s_stream_end && phase_next == PH_LENGTH) begin
            found_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= HeaderSkipReset;
        end else if (cfg_wr_en) begin
            skip_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 8'd0;
            window_reg <= 32'd0;
            length_reg <= 32'd0;
            left_reg   <= 32'd0;
        end else if (s_fire) begin
            if (s_stream_end) begin
                // stream end: result is formed, then the walker starts over
                phase_reg  <= PH_HEADER;
                count_reg  <= 8'd0;
                window_reg <= 32'd0;
                length_reg <= 32'd0;
                left_reg   <= 32'd0;
            end else begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                window_reg <= window_next;
                length_reg <= length_next;
                left_reg   <= left_next;
            end
        end
    end

    // result valid: set by an input transfer, cleared by an output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with each input transfer
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_byte_role    <= role_next;
            m_payload_byte <= s_data_byte;
            m_chunk_id     <= window_next;
            m_chunk_length <= length_next;
            m_chunk_found  <= found_next;
            m_payload_last <= last_next;
            m_id_rejected  <= rej_next;
            m_end_seen     <= s_stream_end;
        end
    end

endmodule

`default_nettype wire

/* design/rcw_checker.sv */
// ----------------------------------------------------------------------------
// rcw_checker
// port-level checks on the result channel of riff_chunk_walker
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_checker
    import rcw_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_byte_role,
    input wire logic        m_chunk_found,
    input wire logic        m_payload_last,
    input wire logic        m_id_rejected,
    input wire logic        m_end_seen
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // the input stalls only behind a full result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

    // last payload byte is tagged as payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_last |-> m_byte_role == ROLE_PAYLOAD)
        else $error("payload_last outside payload");

    // rejection only during identifier search
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_id_rejected |-> m_byte_role == ROLE_SEARCH)
        else $error("id_rejected outside search");

    // chunk found on a length byte, or on an identifier byte cut off by stream end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chunk_found |->
            (m_byte_role == ROLE_LENGTH) || (m_byte_role == ROLE_SEARCH && m_end_seen))
        else $error("chunk_found on unexpected byte");

endmodule

bind riff_chunk_walker rcw_checker u_rcw_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_byte_role    (m_byte_role),
    .m_chunk_found  (m_chunk_found),
    .m_payload_last (m_payload_last),
    .m_id_rejected  (m_id_rejected),
    .m_end_seen     (m_end_seen)
);

`default_nettype wire
